// ===== rtl/core/pidc_pkg.sv =====
package pidc_pkg;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int CFG_W = 31;
    localparam int DIV_STEPS = DW + FB;

    typedef logic signed [DW-1:0] q_t;

    localparam q_t Q_MAX = 32'sh7fffffff;
    localparam q_t Q_MIN = 32'sh80000000;

    // Fixed coefficients, rounded to nearest in Q16.16
    localparam q_t Q_TENTH      = 32'sd6554;
    localparam q_t Q_GATE       = 32'sd64225;
    localparam q_t Q_WINDUP     = 32'sd62259;
    localparam q_t Q_FILT_OLD   = 32'sd55706;
    localparam q_t Q_FILT_NEW   = 32'sd9830;
    localparam q_t Q_SMALL_ERR  = 32'sd66;
    localparam q_t Q_BOOST      = 32'sd7864;
    localparam q_t Q_REST       = 32'sd1311;
    localparam q_t Q_HOLD       = 32'sd3277;
    localparam q_t Q_STABLE_DE  = 32'sd655;
    localparam q_t Q_UNSTABLE   = 32'sd13107;
    localparam logic [CFG_W-1:0] THRESHOLD_RESET = 31'd655;

    typedef enum logic [2:0] {
        REG_KP        = 3'd0,
        REG_KI        = 3'd1,
        REG_KD        = 3'd2,
        REG_LIMIT     = 3'd3,
        REG_DEAD_ZONE = 3'd4,
        REG_THRESHOLD = 3'd5
    } cfg_index_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DZ,
        ST_DZ_CHECK,
        ST_MUL_P,
        ST_MUL_98,
        ST_MUL_95,
        ST_MUL_I1,
        ST_MUL_I2,
        ST_MUL_I3,
        ST_DIV_WAIT,
        ST_FILT1,
        ST_FILT2,
        ST_FILT3,
        ST_MUL_D,
        ST_TAKE_D,
        ST_SUM,
        ST_FINISH,
        ST_OUT
    } state_t;

    // Saturate a 33-bit intermediate into the signed data range
    function automatic q_t sat33(input logic signed [DW:0] v);
        q_t r;
        if (v[DW] != v[DW-1])
            r = v[DW] ? Q_MIN : Q_MAX;
        else
            r = v[DW-1:0];
        return r;
    endfunction

    function automatic q_t add_sat(input q_t a, input q_t b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        return sat33(s);
    endfunction

    function automatic q_t sub_sat(input q_t a, input q_t b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} - {b[DW-1], b};
        return sat33(s);
    endfunction

    function automatic q_t qabs(input q_t v);
        q_t r;
        if (v == Q_MIN)
            r = Q_MAX;
        else if (v[DW-1])
            r = -v;
        else
            r = v;
        return r;
    endfunction

endpackage

// ===== rtl/core/incremental_pid_controller.sv =====
// Incremental (velocity-form) PID controller, signed Q16.16.
// Input channel s_*: one transfer per control step. s_tuser[0] is the command
// (1 clears the controller state and returns 0). s_tdata holds setpoint,
// measurement and time step. Output channel m_*: one drive value per input.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 Kp, 1 Ki,
// 2 Kd, 3 output limit, 4 dead zone ratio, 5 integral threshold); others
// are ignored. Write only while idle.
// Sequence: a clear or a zero time step goes from idle straight to the output
// state; the first step after clear ends after the dead-zone check; a full step
// runs the multiplier states and, with Kd nonzero, also the divider wait and
// filter states. The length is set by a single shared 32x32 multiplier used
// once per cycle and by the radix-2 divider (48 steps) for the derivative term.
// One item is in flight at a time: s_tready is high only in the idle state, so a
// new input is taken only after the previous result has been accepted.
// A stalled result stays on m_tdata until taken; no new input is accepted
// meanwhile. Reset clears all state, sets the first-step and settled flags
// and loads the register defaults (threshold 655, others zero).
module incremental_pid_controller
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // setpoint[31:0], measurement[63:32], time_step[94:64]
    input  logic [0:0]  s_tuser,   // command[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // drive[31:0]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_data
);
    import pidc_pkg::*;

    state_t state_reg, state_next;

    // Configuration
    logic [CFG_W-1:0] kp_reg, ki_reg, kd_reg, limit_reg, dzr_reg, thr_reg;

    // Controller state
    q_t   last_err_reg, prev_err_reg, last_meas_reg, last_drive_reg, facc_reg;
    logic first_reg, settled_reg;

    // Per-step work registers
    q_t               sp_reg, meas_reg, err_reg, aerr_reg, de_reg;
    logic [CFG_W-1:0] dt_reg;
    q_t               p_reg, i_reg, d_reg, r98_reg, r95_reg, t1_reg, y_reg, out_reg;
    logic             gate_reg;

    q_t   mul_a, mul_b, mul_q;
    logic div_start, div_busy, div_done;
    q_t   div_q, div_num;

    logic accept;
    q_t   sp_in, meas_in, e0, sp_mag, lim_q, ld_mag, y_clamped, y_hold, y_final;
    logic kill_i, err_pos, err_neg;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = out_reg;
    assign sp_in    = s_tdata[31:0];
    assign meas_in  = s_tdata[63:32];
    assign lim_q    = q_t'({1'b0, limit_reg});
    assign ld_mag   = qabs(last_drive_reg);
    assign err_pos  = !err_reg[DW-1] && (err_reg != '0);
    assign err_neg  = err_reg[DW-1];

    pidc_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_q)
    );

    pidc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (dt_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // Operand select for the shared multiplier
    always_comb
    begin
        sp_mag = qabs(sp_reg);
        if (sp_mag < Q_TENTH)
            sp_mag = Q_TENTH;
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_DZ:
            begin
                mul_a = q_t'({1'b0, dzr_reg});
                mul_b = sp_mag;
            end
            ST_MUL_P:
            begin
                mul_a = q_t'({1'b0, kp_reg});
                mul_b = de_reg;
            end
            ST_MUL_98:
            begin
                mul_a = lim_q;
                mul_b = Q_GATE;
            end
            ST_MUL_95:
            begin
                mul_a = lim_q;
                mul_b = Q_WINDUP;
            end
            ST_MUL_I1:
            begin
                mul_a = q_t'({1'b0, ki_reg});
                mul_b = err_reg;
            end
            ST_MUL_I2:
            begin
                mul_a = mul_q;
                mul_b = q_t'({1'b0, dt_reg});
            end
            ST_FILT1:
            begin
                mul_a = Q_FILT_OLD;
                mul_b = facc_reg;
            end
            ST_FILT2:
            begin
                mul_a = Q_FILT_NEW;
                mul_b = div_q;
            end
            ST_MUL_D:
            begin
                mul_a = q_t'({1'b0, kd_reg});
                mul_b = facc_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Dead zone, anti-windup, second difference and final output shaping
    always_comb
    begin
        e0 = (qabs(err_reg) < mul_q) ? '0 : err_reg;
        kill_i = (ld_mag >= r95_reg) &&
                 ((!last_drive_reg[DW-1] && last_drive_reg != '0 && err_pos) ||
                  (last_drive_reg[DW-1] && err_neg));
        div_num   = sub_sat(de_reg, sub_sat(last_err_reg, prev_err_reg));
        div_start = (state_reg == ST_MUL_I3) && (kd_reg != '0);

        y_hold = y_clamped;
        if (settled_reg)
        begin
            if (sp_reg > Q_TENTH && y_clamped < -Q_HOLD && err_pos)
                y_hold = -Q_HOLD;
            else if (sp_reg < -Q_TENTH && y_clamped > Q_HOLD && err_neg)
                y_hold = Q_HOLD;
        end
        y_final = y_hold;
        if (last_drive_reg == '0 && qabs(last_meas_reg) < Q_REST && aerr_reg > Q_TENTH)
        begin
            if (err_pos)
            begin
                if (y_hold < Q_BOOST)
                    y_final = Q_BOOST;
            end
            else if (y_hold > -Q_BOOST)
                y_final = -Q_BOOST;
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser[0] || s_tdata[94:64] == '0)
                        state_next = ST_OUT;
                    else
                        state_next = ST_DZ;
                end
            end
            ST_DZ:       state_next = ST_DZ_CHECK;
            ST_DZ_CHECK: state_next = first_reg ? ST_OUT : ST_MUL_P;
            ST_MUL_P:    state_next = ST_MUL_98;
            ST_MUL_98:   state_next = ST_MUL_95;
            ST_MUL_95:   state_next = ST_MUL_I1;
            ST_MUL_I1:   state_next = ST_MUL_I2;
            ST_MUL_I2:   state_next = ST_MUL_I3;
            ST_MUL_I3:   state_next = (kd_reg != '0) ? ST_DIV_WAIT : ST_SUM;
            ST_DIV_WAIT: state_next = div_done ? ST_FILT1 : ST_DIV_WAIT;
            ST_FILT1:    state_next = ST_FILT2;
            ST_FILT2:    state_next = ST_FILT3;
            ST_FILT3:    state_next = ST_MUL_D;
            ST_MUL_D:    state_next = ST_TAKE_D;
            ST_TAKE_D:   state_next = ST_SUM;
            ST_SUM:      state_next = ST_FINISH;
            ST_FINISH:   state_next = ST_OUT;
            ST_OUT:      state_next = m_tready ? ST_IDLE : ST_OUT;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg    <= '0;
            ki_reg    <= '0;
            kd_reg    <= '0;
            limit_reg <= '0;
            dzr_reg   <= '0;
            thr_reg   <= THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KP:        kp_reg    <= cfg_data;
                REG_KI:        ki_reg    <= cfg_data;
                REG_KD:        kd_reg    <= cfg_data;
                REG_LIMIT:     limit_reg <= cfg_data;
                REG_DEAD_ZONE: dzr_reg   <= cfg_data;
                REG_THRESHOLD: thr_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Datapath and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_err_reg   <= '0;
            prev_err_reg   <= '0;
            last_meas_reg  <= '0;
            last_drive_reg <= '0;
            facc_reg       <= '0;
            first_reg      <= 1'b1;
            settled_reg    <= 1'b1;
            sp_reg         <= '0;
            meas_reg       <= '0;
            dt_reg         <= '0;
            err_reg        <= '0;
            aerr_reg       <= '0;
            de_reg         <= '0;
            p_reg          <= '0;
            i_reg          <= '0;
            d_reg          <= '0;
            r98_reg        <= '0;
            r95_reg        <= '0;
            t1_reg         <= '0;
            y_reg          <= '0;
            out_reg        <= '0;
            gate_reg       <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        sp_reg   <= sp_in;
                        meas_reg <= meas_in;
                        dt_reg   <= s_tdata[94:64];
                        err_reg  <= sub_sat(sp_in, meas_in);
                        if (s_tuser[0])
                        begin
                            last_err_reg   <= '0;
                            prev_err_reg   <= '0;
                            last_meas_reg  <= '0;
                            last_drive_reg <= '0;
                            facc_reg       <= '0;
                            first_reg      <= 1'b1;
                            settled_reg    <= 1'b1;
                            out_reg        <= '0;
                        end
                        else
                            out_reg <= last_drive_reg;
                    end
                end
                ST_DZ_CHECK:
                begin
                    err_reg  <= e0;
                    aerr_reg <= qabs(e0);
                    de_reg   <= sub_sat(e0, last_err_reg);
                    if (first_reg)
                    begin
                        last_err_reg   <= e0;
                        prev_err_reg   <= e0;
                        last_meas_reg  <= meas_reg;
                        last_drive_reg <= '0;
                        facc_reg       <= '0;
                        first_reg      <= 1'b0;
                        out_reg        <= '0;
                    end
                end
                ST_MUL_98: p_reg <= mul_q;
                ST_MUL_95: r98_reg <= mul_q;
                ST_MUL_I1:
                begin
                    r95_reg  <= mul_q;
                    gate_reg <= (aerr_reg > q_t'({1'b0, thr_reg})) ||
                                (aerr_reg > Q_SMALL_ERR && ld_mag < r98_reg);
                end
                ST_MUL_I3:
                begin
                    i_reg <= (gate_reg && !kill_i) ? mul_q : '0;
                    d_reg <= '0;
                end
                ST_FILT2:  t1_reg <= mul_q;
                ST_FILT3:  facc_reg <= add_sat(t1_reg, mul_q);
                ST_TAKE_D: d_reg <= mul_q;
                ST_SUM:
                begin
                    y_reg <= add_sat(last_drive_reg,
                                     add_sat(add_sat(p_reg, i_reg), d_reg));
                end
                ST_FINISH:
                begin
                    if (aerr_reg < Q_HOLD && qabs(de_reg) < Q_STABLE_DE)
                        settled_reg <= 1'b1;
                    else if (aerr_reg > Q_UNSTABLE)
                        settled_reg <= 1'b0;
                    prev_err_reg   <= last_err_reg;
                    last_err_reg   <= err_reg;
                    last_meas_reg  <= meas_reg;
                    last_drive_reg <= y_final;
                    out_reg        <= y_final;
                end
                default: ;
            endcase
        end
    end

    // Clamp stage: applied to the sum before shaping
    always_comb
    begin
        y_clamped = y_reg;
        if (y_reg > lim_q)
            y_clamped = lim_q;
        if (y_reg < -lim_q)
            y_clamped = -lim_q;
    end

`ifndef NO_ASSERTIONS
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("input ready while a result is pending");

    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser[0]) |=> (m_tvalid && m_tdata == '0))
        else $error("clear command did not return zero");

    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == ST_DIV_WAIT))
        else $error("divider busy outside its wait state");
`endif

endmodule

// ===== rtl/core/pidc_mul.sv =====
module pidc_mul
(
    input  logic            clk,
    input  logic            rst_n,
    input  pidc_pkg::q_t    a,
    input  pidc_pkg::q_t    b,
    output pidc_pkg::q_t    product
);
    import pidc_pkg::*;

    logic [DW-1:0]   mag_a;
    logic [DW-1:0]   mag_b;
    logic [2*DW-1:0] full;
    logic [DW+FB-1:0] shifted;
    logic [DW+FB-1:0] limit;
    logic            neg;
    logic [DW-1:0]   mag_res;
    q_t              product_next;
    q_t              product_reg;

    // Sign-magnitude fixed-point product, truncated toward zero, saturated
    always_comb
    begin
        mag_a   = a[DW-1] ? (~a + 1'b1) : a;
        mag_b   = b[DW-1] ? (~b + 1'b1) : b;
        neg     = a[DW-1] ^ b[DW-1];
        full    = mag_a * mag_b;
        shifted = full[2*DW-1:FB];
        limit   = neg ? {{FB{1'b0}}, 1'b1, {(DW-1){1'b0}}}
                      : {{(FB+1){1'b0}}, {(DW-1){1'b1}}};
        if (shifted > limit)
            mag_res = limit[DW-1:0];
        else
            mag_res = shifted[DW-1:0];
        product_next = neg ? q_t'(~mag_res + 1'b1) : q_t'(mag_res);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            product_reg <= '0;
        else
            product_reg <= product_next;
    end

    assign product = product_reg;

endmodule

// ===== rtl/core/pidc_div.sv =====
module pidc_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  pidc_pkg::q_t                  num,
    input  logic [pidc_pkg::CFG_W-1:0]    den,
    output logic                          busy,
    output logic                          done,
    output pidc_pkg::q_t                  quotient
);
    import pidc_pkg::*;

    localparam int CW = $clog2(DIV_STEPS + 1);

    logic [CW-1:0]        count_reg;
    logic [DIV_STEPS-1:0] shift_reg;
    logic [CFG_W-1:0]     rem_reg;
    logic                 neg_reg;
    logic                 busy_reg;
    logic                 done_reg;
    q_t                   quot_reg;

    logic [CFG_W:0]       trial;
    logic                 fits;
    logic [CFG_W-1:0]     rem_next;
    logic [DIV_STEPS-1:0] shift_next;
    logic [DW-1:0]        num_mag;
    logic [DW-1:0]        sat_mag;

    // One restoring step per cycle: one quotient bit
    always_comb
    begin
        trial      = {rem_reg, shift_reg[DIV_STEPS-1]};
        fits       = trial >= {1'b0, den};
        rem_next   = fits ? CFG_W'(trial - {1'b0, den}) : trial[CFG_W-1:0];
        shift_next = {shift_reg[DIV_STEPS-2:0], fits};
        num_mag    = num[DW-1] ? (~num + 1'b1) : num;
        if (shift_next[DIV_STEPS-1:DW-1] != '0)
            sat_mag = {1'b1, {(DW-1){1'b0}}};
        else
            sat_mag = shift_next[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            shift_reg <= '0;
            rem_reg   <= '0;
            neg_reg   <= 1'b0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            quot_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                shift_reg <= {num_mag, {FB{1'b0}}};
                rem_reg   <= '0;
                neg_reg   <= num[DW-1];
                count_reg <= CW'(DIV_STEPS);
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                shift_reg <= shift_next;
                rem_reg   <= rem_next;
                count_reg <= count_reg - 1'b1;
                if (count_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    // Negative side reaches the minimum, positive side clamps
                    if (neg_reg)
                        quot_reg <= q_t'(~sat_mag + 1'b1);
                    else if (sat_mag[DW-1])
                        quot_reg <= Q_MAX;
                    else
                        quot_reg <= q_t'(sat_mag);
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule
